/* hdl/rtp_receive_statistics_assert.svh */
// Assertion macros shared by the statistics block.
// RTPS_ASSERT_IMPLY checks a consequent in the same cycle as its antecedent.
// RTPS_ASSERT_NEXT checks a consequent in the cycle after its antecedent.
`ifndef RTP_RECEIVE_STATISTICS_ASSERT_SVH
`define RTP_RECEIVE_STATISTICS_ASSERT_SVH

`define RTPS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define RTPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/rtps_pkg.sv */
package rtps_pkg;

   // Window table geometry.
   localparam int WINDOW_DEPTH = 4096;
   localparam int SLOT_BITS    = $clog2(WINDOW_DEPTH);

   // Jitter filter: fixed point with a gain of 1/16.
   localparam int JITTER_FRAC_BITS  = 8;
   localparam int JITTER_GAIN_SHIFT = 4;
   localparam int JITTER_STATE_BITS = 40;
   localparam int JITTER_OUT_BITS   = 39;
   localparam int JITTER_X_BITS     = 32 + JITTER_FRAC_BITS;
   localparam int JIT_WORK_BITS     =
      ((JITTER_X_BITS > JITTER_STATE_BITS) ? JITTER_X_BITS : JITTER_STATE_BITS) + 2;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Stream widths.
   localparam int REQ_DATA_BITS = 104;
   localparam int RSP_DATA_BITS = 232;
   localparam int RSP_USER_BITS = 3;

   // Header checks.
   localparam logic [15:0] MIN_PACKET_LENGTH = 16'd12;
   localparam logic [7:0]  VERSION_MASK      = 8'hC0;
   localparam logic [7:0]  VERSION_V2        = 8'h80;

   // Register file.
   localparam int          CSR_ADDR_BITS      = 3;
   localparam logic [15:0] WRAP_RESET         = 16'd30000;
   localparam logic        REG_WRAP_THRESHOLD = 1'b0;

   // One packet as it leaves the front part.
   typedef struct packed {
      logic        accepted;
      logic [31:0] ext;
      logic [31:0] transit;
   } entry_type;

   // One window slot in memory.
   typedef struct packed {
      logic        valid;
      logic [31:0] ext;
   } slot_type;

   // Result snapshot carried down the back pipeline.
   typedef struct packed {
      logic                       accepted;
      logic [31:0]                ext;
      logic                       dup;
      logic                       reord;
      logic [31:0]                unique_cnt;
      logic [31:0]                dup_cnt;
      logic [31:0]                reord_cnt;
      logic [31:0]                expected;
      logic [31:0]                lost;
      logic [JITTER_OUT_BITS-1:0] jitter;
      logic [31:0]                highest;
      logic [31:0]                first;
      logic                       started;
   } stat_type;

   // Saturating increment of a 32-bit counter.
   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hffff_ffff) ? v : v + 32'd1;
   endfunction

endpackage

/* hdl/rtps_front.sv */
module rtps_front
   import rtps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic [15:0]              wrap_threshold,
   input  logic                     queue_full,
   input  logic                     clear_busy,
   output logic                     push,
   output entry_type                entry
);

   logic [7:0]  version_byte;
   logic [15:0] packet_length;
   logic [15:0] sequence_number;
   logic [31:0] media_timestamp;
   logic [31:0] arrival_time;
   logic        header_ok;
   logic        wrap;
   logic [15:0] seq_step;
   logic [15:0] wrap_cycles_in;
   logic        take;

   logic        seq_started_ff;
   logic [15:0] wrap_cycles_ff;
   logic [15:0] previous_seq_ff;

   // Unpack the header fields.
   assign version_byte    = req_tdata[7:0];
   assign packet_length   = req_tdata[23:8];
   assign sequence_number = req_tdata[39:24];
   assign media_timestamp = req_tdata[71:40];
   assign arrival_time    = req_tdata[103:72];

   assign req_tready = !queue_full && !clear_busy;
   assign push       = req_tvalid && req_tready;

   // Classify the packet and extend its sequence number.
   always_comb begin
      header_ok = (packet_length >= MIN_PACKET_LENGTH) &&
                  ((version_byte & VERSION_MASK) == VERSION_V2);
      seq_step  = previous_seq_ff - sequence_number;
      wrap      = seq_started_ff && (sequence_number < previous_seq_ff) &&
                  (seq_step > wrap_threshold);
      wrap_cycles_in = wrap ? wrap_cycles_ff + 16'd1 : wrap_cycles_ff;
      take      = push && header_ok;

      entry.accepted = header_ok;
      entry.ext      = header_ok ? {wrap_cycles_in, sequence_number} : 32'd0;
      entry.transit  = arrival_time - media_timestamp;
   end

   // Sequence tracking state changes only for accepted packets.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_started_ff  <= 1'b0;
         wrap_cycles_ff  <= 16'd0;
         previous_seq_ff <= 16'd0;
      end else if (take) begin
         seq_started_ff  <= 1'b1;
         wrap_cycles_ff  <= wrap_cycles_in;
         previous_seq_ff <= sequence_number;
      end
   end

endmodule

/* hdl/rtps_fifo.sv */
module rtps_fifo
   import rtps_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);

   entry_type                 slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff;

   assign head  = slots_ff[rd_ptr_ff];
   assign full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* hdl/rtps_back.sv */
`include "rtp_receive_statistics_assert.svh"

module rtps_back
   import rtps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  entry_type                head,
   input  logic                     queue_empty,
   output logic                     pop,
   output logic                     clear_busy,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [RSP_USER_BITS-1:0] rsp_tuser
);

   // Window memory and its clearing pass.
   slot_type            window_mem [WINDOW_DEPTH];
   slot_type            rd_data_ff;
   logic                clear_busy_ff;
   logic [SLOT_BITS-1:0] clear_addr_ff;
   logic                mem_we;
   logic [SLOT_BITS-1:0] mem_wa;
   slot_type            mem_wd;
   logic [SLOT_BITS-1:0] rd_addr;

   // Read stage.
   logic                go;
   logic [31:0]         transit_diff;
   logic [31:0]         transit_mag;
   logic                bypass_in;
   logic                transit_started_ff;
   logic [31:0]         transit_prev_ff;

   // Execute stage.
   logic                s1_valid_ff;
   logic                s1_acc_ff;
   logic [31:0]         s1_ext_ff;
   logic [31:0]         s1_mag_ff;
   logic                s1_jit_en_ff;
   logic                s1_byp_ff;
   logic [31:0]         s1_byp_ext_ff;
   logic [SLOT_BITS-1:0] s1_slot;
   logic                hit_valid;
   logic [31:0]         hit_ext;
   logic                s1_dup;
   logic                s1_reord;
   logic                s1_upd;
   logic                s1_write;
   logic                s1_first;
   logic [31:0]         hi_cur;

   // Stream state.
   logic                seq_started_ff;
   logic [31:0]         first_ff;
   logic [31:0]         highest_ff;
   logic [31:0]         unique_ff;
   logic [31:0]         dup_cnt_ff;
   logic [31:0]         reord_cnt_ff;
   logic [JITTER_STATE_BITS-1:0] jitter_ff;
   logic                seq_started_in;
   logic [31:0]         first_in;
   logic [31:0]         highest_in;
   logic [31:0]         unique_in;
   logic [31:0]         dup_cnt_in;
   logic [31:0]         reord_cnt_in;
   logic [JITTER_STATE_BITS-1:0] jitter_in;

   // Jitter arithmetic.
   logic signed [JIT_WORK_BITS-1:0] jit_x;
   logic signed [JIT_WORK_BITS-1:0] jit_j;
   logic signed [JIT_WORK_BITS-1:0] jit_delta;
   logic signed [JIT_WORK_BITS-1:0] jit_sum;
   logic [JITTER_STATE_BITS-1:0]    jit_new;

   // Result stages.
   logic                s2_valid_ff;
   stat_type            s2_ff;
   stat_type            s2_in;
   logic                s3_valid_ff;
   stat_type            s3_ff;
   stat_type            s3_in;
   logic                out_valid_ff;
   stat_type            out_ff;
   stat_type            out_in;

   // The whole back pipeline advances when the output register can move.
   assign go         = !out_valid_ff || rsp_tready;
   assign pop        = go && !queue_empty && !clear_busy_ff;
   assign clear_busy = clear_busy_ff;
   assign rd_addr    = head.ext[SLOT_BITS-1:0];

   // Read stage: transit difference magnitude and the bypass check.
   always_comb begin
      transit_diff = head.transit - transit_prev_ff;
      transit_mag  = transit_diff[31] ? (32'd0 - transit_diff) : transit_diff;
      bypass_in    = s1_write && (s1_slot == rd_addr);
   end

   // Execute stage: duplicate test, counters and window write.
   always_comb begin
      s1_slot   = s1_ext_ff[SLOT_BITS-1:0];
      hit_valid = s1_byp_ff ? 1'b1 : rd_data_ff.valid;
      hit_ext   = s1_byp_ff ? s1_byp_ext_ff : rd_data_ff.ext;
      s1_upd    = s1_valid_ff && s1_acc_ff;
      s1_dup    = s1_acc_ff && hit_valid && (hit_ext == s1_ext_ff);
      s1_write  = s1_upd && !s1_dup;
      s1_first  = !seq_started_ff;
      hi_cur    = s1_first ? s1_ext_ff : highest_ff;
      s1_reord  = s1_acc_ff && !s1_dup && (s1_ext_ff < hi_cur);

      seq_started_in = seq_started_ff;
      first_in       = first_ff;
      highest_in     = highest_ff;
      unique_in      = unique_ff;
      dup_cnt_in     = dup_cnt_ff;
      reord_cnt_in   = reord_cnt_ff;
      jitter_in      = jitter_ff;

      // J moves by (x - J) / 16 rounded toward minus infinity.
      jit_x     = JIT_WORK_BITS'(s1_mag_ff) <<< JITTER_FRAC_BITS;
      jit_j     = JIT_WORK_BITS'(jitter_ff);
      jit_delta = jit_x - jit_j;
      jit_sum   = jit_j + (jit_delta >>> JITTER_GAIN_SHIFT);
      if (jit_sum[JIT_WORK_BITS-1:JITTER_STATE_BITS] != '0) begin
         jit_new = '1;
      end else begin
         jit_new = jit_sum[JITTER_STATE_BITS-1:0];
      end

      if (s1_upd) begin
         seq_started_in = 1'b1;
         if (s1_first) begin
            first_in = s1_ext_ff;
         end
         if (s1_dup) begin
            dup_cnt_in = sat_inc(dup_cnt_ff);
            highest_in = hi_cur;
         end else begin
            unique_in  = sat_inc(unique_ff);
            highest_in = (s1_ext_ff > hi_cur) ? s1_ext_ff : hi_cur;
            if (s1_reord) begin
               reord_cnt_in = sat_inc(reord_cnt_ff);
            end
         end
         if (s1_jit_en_ff) begin
            jitter_in = jit_new;
         end
      end

      s2_in.accepted   = s1_acc_ff;
      s2_in.ext        = s1_ext_ff;
      s2_in.dup        = s1_dup;
      s2_in.reord      = s1_reord;
      s2_in.unique_cnt = unique_in;
      s2_in.dup_cnt    = dup_cnt_in;
      s2_in.reord_cnt  = reord_cnt_in;
      s2_in.expected   = 32'd0;
      s2_in.lost       = 32'd0;
      s2_in.jitter     = jitter_in[JITTER_STATE_BITS-1] ? '1 :
                         jitter_in[JITTER_OUT_BITS-1:0];
      s2_in.highest    = highest_in;
      s2_in.first      = first_in;
      s2_in.started    = seq_started_in;
   end

   // Expected and lost counts, one subtraction per stage.
   always_comb begin
      s3_in = s2_ff;
      s3_in.expected = s2_ff.started ? (s2_ff.highest - s2_ff.first + 32'd1) : 32'd0;
      out_in = s3_ff;
      out_in.lost = (s3_ff.expected > s3_ff.unique_cnt) ?
                    (s3_ff.expected - s3_ff.unique_cnt) : 32'd0;
   end

   // Memory write port, shared with the clearing pass.
   always_comb begin
      mem_we = clear_busy_ff || (go && s1_write);
      mem_wa = clear_busy_ff ? clear_addr_ff : s1_slot;
      mem_wd = clear_busy_ff ? slot_type'('0) : slot_type'({1'b1, s1_ext_ff});
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem[mem_wa] <= mem_wd;
      end
      if (go) begin
         rd_data_ff <= window_mem[rd_addr];
      end
   end

   // Clearing pass after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_busy_ff) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
         if (clear_addr_ff == SLOT_BITS'(WINDOW_DEPTH - 1)) begin
            clear_busy_ff <= 1'b0;
         end
      end
   end

   // Pipeline valid bits and transit tracking.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         s2_valid_ff        <= 1'b0;
         s3_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         transit_started_ff <= 1'b0;
         transit_prev_ff    <= 32'd0;
      end else if (go) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
         if (pop && head.accepted) begin
            transit_started_ff <= 1'b1;
            transit_prev_ff    <= head.transit;
         end
      end
   end

   // Stream state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_started_ff <= 1'b0;
         first_ff       <= 32'd0;
         highest_ff     <= 32'd0;
         unique_ff      <= 32'd0;
         dup_cnt_ff     <= 32'd0;
         reord_cnt_ff   <= 32'd0;
         jitter_ff      <= '0;
      end else if (go) begin
         seq_started_ff <= seq_started_in;
         first_ff       <= first_in;
         highest_ff     <= highest_in;
         unique_ff      <= unique_in;
         dup_cnt_ff     <= dup_cnt_in;
         reord_cnt_ff   <= reord_cnt_in;
         jitter_ff      <= jitter_in;
      end
   end

   // Payload registers of the stages.
   always_ff @(posedge clock) begin
      if (go) begin
         s1_acc_ff     <= head.accepted;
         s1_ext_ff     <= head.ext;
         s1_mag_ff     <= transit_mag;
         s1_jit_en_ff  <= head.accepted && transit_started_ff;
         s1_byp_ff     <= bypass_in;
         s1_byp_ext_ff <= s1_ext_ff;
         s2_ff         <= s2_in;
         s3_ff         <= s3_in;
         out_ff        <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.jitter, out_ff.lost, out_ff.expected,
                        out_ff.reord_cnt, out_ff.dup_cnt, out_ff.unique_cnt, out_ff.ext};
   assign rsp_tuser  = {out_ff.reord, out_ff.dup, out_ff.accepted};

   `RTPS_ASSERT_IMPLY(a_no_item_while_clearing, clock, reset, clear_busy_ff, !s1_valid_ff && !pop, "item in flight during window clearing")
   `RTPS_ASSERT_IMPLY(a_dup_excludes_reorder, clock, reset, s2_valid_ff && s2_ff.dup, !s2_ff.reord && s2_ff.accepted, "duplicate also flagged reordered or rejected")
   `RTPS_ASSERT_NEXT(a_unique_monotonic, clock, reset, 1'b1, unique_ff >= $past(unique_ff), "unique count decreased")
   `RTPS_ASSERT_NEXT(a_no_write_on_stall, clock, reset, !go && !clear_busy_ff, $stable(unique_ff) && $stable(jitter_ff), "state changed while the pipeline was stalled")

endmodule

/* hdl/rtp_receive_statistics.sv */
// RTP receive statistics for one stream. Each header transfer on the req_
// channel yields exactly one result transfer on the rsp_ channel, in order.
// The block sustains one packet per clock while the result side does not
// stall. A packet is registered in the queue, then in the s1, s2 and s3
// stage registers, and last in the output register that drives rsp_tvalid.
// The rate is set by the window table read-modify-write, a memory of
// WINDOW_DEPTH slots with one read and one write port, whose read is
// registered and whose last write is bypassed to the following packet. A
// four-entry queue between the classifying front end and the statistics
// pipeline lets requests be taken while a result waits. After reset the
// window table is cleared one slot per cycle; req_tready stays low until
// it is done, while register writes are taken as usual. The only register,
// at byte address 0, is wrap_threshold (16 bits, reset 30000).
module rtp_receive_statistics
   import rtps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // version_byte[7:0], packet_length[23:8], sequence_number[39:24],
   // media_timestamp[71:40], arrival_time[103:72]
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // extended_seq[31:0], unique_count[63:32], duplicate_count[95:64],
   // reorder_count[127:96], expected_count[159:128], lost_count[191:160],
   // jitter_fixed[230:192], zero pad[231]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // accepted[0], is_duplicate[1], is_reordered[2]
   output logic [RSP_USER_BITS-1:0] rsp_tuser,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic [15:0] wrap_threshold_reg_ff;
   logic        csr_write;
   logic        csr_index;
   logic        push;
   logic        pop;
   logic        queue_full;
   logic        queue_empty;
   logic        clear_busy;
   entry_type   push_entry;
   entry_type   head;

   // Register port: one 32-bit word per register.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_index == REG_WRAP_THRESHOLD) ?
                       {16'd0, wrap_threshold_reg_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_threshold_reg_ff <= WRAP_RESET;
      end else if (csr_write && (csr_index == REG_WRAP_THRESHOLD)) begin
         wrap_threshold_reg_ff <= csr_pwdata[15:0];
      end
   end

   rtps_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .wrap_threshold (wrap_threshold_reg_ff),
      .queue_full     (queue_full),
      .clear_busy     (clear_busy),
      .push           (push),
      .entry          (push_entry)
   );

   rtps_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   rtps_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .queue_empty (queue_empty),
      .pop         (pop),
      .clear_busy  (clear_busy),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
